[sv/salru_pkg.sv]
// shared types and constants for the set-associative lru cache model
// fsm states, access and register codes, lookup status, saturating increment
// no dependencies
package salru_pkg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOOK
    } state_t;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_STORE  = 2'd1;
    localparam logic [1:0] MODE_MODIFY = 2'd2;

    localparam logic [1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS       = 2'd2;

    localparam int CNT_W       = 32;
    localparam int CFG_W       = 6;
    localparam int OUT_TDATA_W = 104;

    typedef struct packed {
        logic hit;
        logic evicted;
    } look_stat_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

endpackage

[sv/salru_ram.sv]
// generic single write port, single read port ram with registered read
// depends on nothing
module salru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/salru_lookup.sv]
// one lookup on a whole set row: hit search, fill or lru victim, recency update
// depends on salru_pkg
module salru_lookup #(
    parameter int WAYS   = 4,
    parameter int TAG_W  = 64,
    parameter int RANK_W = 2
) (
    input  logic [WAYS*(TAG_W+RANK_W+1)-1:0] row_in,
    input  logic [TAG_W-1:0]                 tag,
    input  logic [WAYS-1:0]                  way_en,
    output logic [WAYS*(TAG_W+RANK_W+1)-1:0] row_out,
    output salru_pkg::look_stat_t            stat
);
    import salru_pkg::*;

    localparam int WAY_W = TAG_W + RANK_W + 1;
    localparam int IDX_W = WAYS > 1 ? $clog2(WAYS) : 1;

    logic [WAYS-1:0]   valid;
    logic [RANK_W-1:0] rank [WAYS];
    logic [TAG_W-1:0]  tags [WAYS];

    logic              hit;
    logic              has_inv;
    logic [IDX_W-1:0]  hit_way;
    logic [IDX_W-1:0]  inv_way;
    logic [IDX_W-1:0]  victim;
    logic [RANK_W-1:0] best;
    logic [IDX_W-1:0]  target;
    logic [RANK_W-1:0] old_rank;
    logic              age_all;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            tags[w]  = row_in[w*WAY_W +: TAG_W];
            rank[w]  = row_in[w*WAY_W + TAG_W +: RANK_W];
            valid[w] = row_in[w*WAY_W + TAG_W + RANK_W];
        end
    end

    always_comb begin
        hit     = 1'b0;
        hit_way = '0;
        has_inv = 1'b0;
        inv_way = '0;
        victim  = '0;
        best    = rank[0];
        for (int w = 0; w < WAYS; w++) begin
            if (!hit && way_en[w] && valid[w] && tags[w] == tag) begin
                hit     = 1'b1;
                hit_way = IDX_W'(w);
            end
            if (!has_inv && way_en[w] && !valid[w]) begin
                has_inv = 1'b1;
                inv_way = IDX_W'(w);
            end
        end
        for (int w = 1; w < WAYS; w++) begin
            if (way_en[w] && rank[w] > best) begin
                best   = rank[w];
                victim = IDX_W'(w);
            end
        end

        // fill ages every enabled valid line, hit and evict age only younger enabled lines
        age_all = !hit && has_inv;
        if (hit) begin
            target   = hit_way;
            old_rank = rank[hit_way];
        end else if (has_inv) begin
            target   = inv_way;
            old_rank = '0;
        end else begin
            target   = victim;
            old_rank = best;
        end

        row_out = row_in;
        for (int w = 0; w < WAYS; w++) begin
            if (IDX_W'(w) == target) begin
                row_out[w*WAY_W +: TAG_W]            = tag;
                row_out[w*WAY_W + TAG_W +: RANK_W]   = '0;
                row_out[w*WAY_W + TAG_W + RANK_W]    = 1'b1;
            end else if (way_en[w] && valid[w] && (age_all || rank[w] < old_rank)
                         && rank[w] < RANK_W'(WAYS - 1)) begin
                row_out[w*WAY_W + TAG_W +: RANK_W]   = rank[w] + 1'b1;
            end
        end

        stat.hit     = hit;
        stat.evicted = !hit && !has_inv;
    end

endmodule

[sv/set_assoc_cache_lru_sim.sv]
// top level of the tag-only set-associative cache with lru replacement
// holds config registers, access fsm, counters and output register
// depends on salru_pkg, salru_ram, salru_lookup
//
//  channel  | ports                        | content
//  ---------+------------------------------+--------------------------------------
//  config   | cfg_we cfg_index cfg_wdata   | 0 set_bits, 1 block_bits, 2 ways_in_use
//  input    | s_tvalid s_tready s_tdata    | tdata address, tuser access mode
//  result   | m_tvalid m_tready m_tdata    | per-item flags and running totals
//
//  load or store: one read and one write back of the set row through the
//  registered-read set ram; modify: two such read and write-back passes
//  after reset a clearing pass writes all 2**MAX_SET_BITS rows, one per cycle,
//  with s_tready low; config writes are taken throughout
//  a held result stalls only the last lookup of the following item
module set_assoc_cache_lru_sim #(
    parameter int MAX_SET_BITS  = 6,
    parameter int MAX_WAYS      = 4,
    parameter int ADDRESS_WIDTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [1:0]                             cfg_index,
    input  logic [salru_pkg::CFG_W-1:0]            cfg_wdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // access_address
    input  logic [((ADDRESS_WIDTH+7)/8)*8-1:0]     s_tdata,
    // mode
    input  logic [1:0]                             s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // hits_now, missed_now, evicted_now, total_hits, total_misses, total_evictions
    output logic [salru_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import salru_pkg::*;

    localparam int SETS   = 1 << MAX_SET_BITS;
    localparam int SET_W  = MAX_SET_BITS > 0 ? MAX_SET_BITS : 1;
    localparam int RANK_W = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_W  = ADDRESS_WIDTH + RANK_W + 1;
    localparam int ROW_W  = MAX_WAYS * WAY_W;
    localparam int SH_W   = 7;

    state_t state_reg, state_next;

    logic [2:0]       set_bits_reg;
    logic [5:0]       block_bits_reg;
    logic [2:0]       ways_reg;

    logic [1:0]               mode_reg;
    logic [ADDRESS_WIDTH-1:0] tag_reg;
    logic [SET_W-1:0]         set_reg;
    logic [SET_W-1:0]         clr_reg, clr_next;
    logic                     pass2_reg, pass2_next;
    logic                     hit1_reg, hit1_next;
    logic                     miss1_reg, miss1_next;
    logic                     ev1_reg, ev1_next;

    logic [CNT_W-1:0] hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0] miss_cnt_reg, miss_cnt_next;
    logic [CNT_W-1:0] ev_cnt_reg, ev_cnt_next;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [1:0]       out_hits_reg, out_hits_next;
    logic             out_missed_reg, out_missed_next;
    logic             out_evicted_reg, out_evicted_next;
    logic [CNT_W-1:0] out_hit_tot_reg, out_miss_tot_reg, out_ev_tot_reg;

    logic [ADDRESS_WIDTH-1:0] addr;
    logic [ADDRESS_WIDTH-1:0] set_shift;
    logic [SET_W-1:0]         set_mask;
    logic [SET_W-1:0]         in_set;
    logic [ADDRESS_WIDTH-1:0] in_tag;
    logic [2:0]               set_eff;
    logic [SH_W-1:0]          tag_shift;
    logic [MAX_WAYS-1:0]      way_en;

    logic             ram_we, ram_re;
    logic [SET_W-1:0] ram_waddr, ram_raddr;
    logic [ROW_W-1:0] ram_wdata, ram_rdata, look_row;
    look_stat_t       stat;

    logic do_lookup;
    logic count_en;
    logic load_out;

    // address split
    always_comb begin
        addr      = s_tdata[ADDRESS_WIDTH-1:0];
        set_eff   = (int'(set_bits_reg) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_reg;
        set_shift = addr >> block_bits_reg;
        for (int i = 0; i < SET_W; i++) begin
            set_mask[i] = (i < int'(set_bits_reg)) && (i < MAX_SET_BITS);
        end
        in_set    = set_shift[SET_W-1:0] & set_mask;
        tag_shift = SH_W'(block_bits_reg) + SH_W'(set_eff);
        in_tag    = addr >> tag_shift;
        for (int w = 0; w < MAX_WAYS; w++) begin
            way_en[w] = (w == 0) || (w < int'(ways_reg));
        end
    end

    salru_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_set_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    salru_lookup #(
        .WAYS   (MAX_WAYS),
        .TAG_W  (ADDRESS_WIDTH),
        .RANK_W (RANK_W)
    ) u_lookup (
        .row_in  (ram_rdata),
        .tag     (tag_reg),
        .way_en  (way_en),
        .row_out (look_row),
        .stat    (stat)
    );

    always_comb begin
        case (mode_reg)
            MODE_LOAD, MODE_STORE, MODE_MODIFY: do_lookup = 1'b1;
            default:                            do_lookup = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = in_set;
        ram_we     = 1'b0;
        ram_waddr  = set_reg;
        ram_wdata  = look_row;
        clr_next   = clr_reg;
        pass2_next = pass2_reg;
        hit1_next  = hit1_reg;
        miss1_next = miss1_reg;
        ev1_next   = ev1_reg;
        count_en   = 1'b0;
        load_out   = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == SET_W'(SETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ram_re     = 1'b1;
                    pass2_next = 1'b0;
                    state_next = ST_LOOK;
                end
            end
            ST_READ: begin
                ram_re     = 1'b1;
                ram_raddr  = set_reg;
                state_next = ST_LOOK;
            end
            ST_LOOK: begin
                if (mode_reg == MODE_MODIFY && !pass2_reg) begin
                    ram_we     = 1'b1;
                    count_en   = 1'b1;
                    hit1_next  = stat.hit;
                    miss1_next = !stat.hit;
                    ev1_next   = stat.evicted;
                    pass2_next = 1'b1;
                    state_next = ST_READ;
                end else if (!m_tvalid_reg || m_tready) begin
                    ram_we     = do_lookup;
                    count_en   = do_lookup;
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        hit_cnt_next  = (count_en && stat.hit) ? sat_inc(hit_cnt_reg) : hit_cnt_reg;
        miss_cnt_next = (count_en && !stat.hit) ? sat_inc(miss_cnt_reg) : miss_cnt_reg;
        ev_cnt_next   = (count_en && stat.evicted) ? sat_inc(ev_cnt_reg) : ev_cnt_reg;

        out_hits_next    = do_lookup ? {1'b0, pass2_reg && hit1_reg} + {1'b0, stat.hit}
                                     : 2'd0;
        out_missed_next  = do_lookup && (pass2_reg ? miss1_reg : !stat.hit);
        out_evicted_next = do_lookup && ((pass2_reg && ev1_reg) || stat.evicted);

        if (load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            pass2_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            ev_cnt_reg     <= '0;
            set_bits_reg   <= 3'd0;
            block_bits_reg <= 6'd0;
            ways_reg       <= 3'd1;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            pass2_reg    <= pass2_next;
            m_tvalid_reg <= m_tvalid_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            ev_cnt_reg   <= ev_cnt_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SET_BITS:   set_bits_reg   <= cfg_wdata[2:0];
                    CFG_BLOCK_BITS: block_bits_reg <= cfg_wdata[5:0];
                    CFG_WAYS:       ways_reg       <= cfg_wdata[2:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        hit1_reg  <= hit1_next;
        miss1_reg <= miss1_next;
        ev1_reg   <= ev1_next;
        if (s_tvalid && s_tready) begin
            mode_reg <= s_tuser;
            tag_reg  <= in_tag;
            set_reg  <= in_set;
        end
        if (load_out) begin
            out_hits_reg     <= out_hits_next;
            out_missed_reg   <= out_missed_next;
            out_evicted_reg  <= out_evicted_next;
            out_hit_tot_reg  <= hit_cnt_next;
            out_miss_tot_reg <= miss_cnt_next;
            out_ev_tot_reg   <= ev_cnt_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - 3*CNT_W - 4){1'b0}},
                       out_ev_tot_reg, out_miss_tot_reg, out_hit_tot_reg,
                       out_evicted_reg, out_missed_reg, out_hits_reg};

    // the set ram never sees a read and a write in the same cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("set ram read and write overlap");

    // an eviction always comes with a missed first lookup
    a_evict_implies_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && out_evicted_reg) |-> out_missed_reg)
        else $error("eviction reported without a miss");

    // running hit total never goes down from one result to the next
    a_hits_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> (!m_tvalid_reg || out_hit_tot_reg >= $past(out_hit_tot_reg)))
        else $error("hit total decreased");

endmodule
